/* rtl/key_matrix_debounce_report_macros.svh */
// Assertion helpers shared by the key matrix debounce RTL.
`ifndef KEY_MATRIX_DEBOUNCE_REPORT_MACROS_SVH
`define KEY_MATRIX_DEBOUNCE_REPORT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define KMDR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in a cycle implies a condition in the next.
`define KMDR_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* rtl/kmdr_pkg.sv */
`timescale 1ns / 1ps

package kmdr_pkg;

	localparam int ROWS         = 6;
	localparam int COLUMNS      = 14;
	localparam int REPORT_SLOTS = 6;
	localparam int MENU_DEPTH   = 10;
	localparam int NKEYS        = ROWS * COLUMNS;

	localparam int ROW_W   = 3;
	localparam int COL_W   = 4;
	localparam int LOC_W   = $clog2(NKEYS);
	localparam int CODE_W  = 8;
	localparam int COUNT_W = 3;
	localparam int LEVEL_W = 4;
	localparam int CURS_W  = 4;

	localparam logic [CODE_W-1:0] CODE_ESC    = 8'h29;
	localparam logic [CODE_W-1:0] CODE_F1     = 8'h3A;
	localparam logic [CODE_W-1:0] CODE_F2     = 8'h3B;
	localparam logic [CODE_W-1:0] CODE_UP     = 8'h52;
	localparam logic [CODE_W-1:0] CODE_DOWN   = 8'h51;
	localparam logic [CODE_W-1:0] CODE_ENTER  = 8'h28;
	localparam logic [CODE_W-1:0] CODE_CIRCLE = 8'hA4;

	localparam logic [LEVEL_W-1:0] BACKLIGHT_RESET = 4'd8;
	localparam logic [LEVEL_W-1:0] BACKLIGHT_MAX   = 4'd10;
	localparam logic [LEVEL_W-1:0] BACKLIGHT_STEP  = 4'd2;

	typedef enum logic {
		KIND_REPORT = 1'b0,
		KIND_META   = 1'b1
	} result_kind_t;

	typedef logic [CODE_W-1:0] key_code_t;

	typedef struct packed {
		result_kind_t                       kind;
		logic [REPORT_SLOTS-1:0][CODE_W-1:0] keys;
		logic [COUNT_W-1:0]                 count;
		key_code_t                          meta_code;
		logic                               meta_stays;
		logic [LEVEL_W-1:0]                 backlight;
		logic [CURS_W-1:0]                  cursor;
	} result_item_t;

	localparam key_code_t KEY_MAP [NKEYS] = '{
		8'h29,8'h3A,8'h3B,8'h3C,8'h3D,8'h3E,8'h3F,8'h40,8'h41,8'h42,8'h43,8'h44,8'h45,8'hA4,
		8'h35,8'h1E,8'h1F,8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'h27,8'h2D,8'h2E,8'h2A,
		8'h2B,8'h14,8'h1A,8'h08,8'h15,8'h17,8'h1C,8'h18,8'h0C,8'h12,8'h13,8'h2F,8'h30,8'h31,
		8'hE0,8'h65,8'h04,8'h16,8'h07,8'h09,8'h0A,8'h0B,8'h0D,8'h0E,8'h0F,8'h33,8'h34,8'h28,
		8'hE1,8'h4C,8'h1D,8'h1B,8'h06,8'h19,8'h05,8'h11,8'h10,8'h36,8'h37,8'h38,8'h52,8'hE5,
		8'hE7,8'hE3,8'hE4,8'h2C,8'hE2,8'hE6,8'h2C,8'h4B,8'h4E,8'h50,8'h51,8'h4F,8'h00,8'h00
	};

	localparam key_code_t MENU_MAP [MENU_DEPTH] = '{
		8'h29, 8'h1E, 8'h27, 8'h15, 8'h05, 8'h3A, 8'h3B, 8'h2C, 8'h16, 8'h13
	};

endpackage

/* rtl/kmdr_sample_if.sv */
`timescale 1ns / 1ps

interface kmdr_sample_if;
	logic                          valid;
	logic                          ready;
	logic [kmdr_pkg::ROW_W-1:0]    row_index;
	logic [kmdr_pkg::COL_W-1:0]    column_index;
	logic                          raw_pressed;
	logic                          scan_end;
	logic                          report_enable;

	modport source (
		output valid, row_index, column_index, raw_pressed, scan_end, report_enable,
		input  ready
	);
	modport sink (
		input  valid, row_index, column_index, raw_pressed, scan_end, report_enable,
		output ready
	);
endinterface

/* rtl/kmdr_result_if.sv */
`timescale 1ns / 1ps

interface kmdr_result_if;
	logic                           valid;
	logic                           ready;
	logic                           result_kind;
	logic [kmdr_pkg::CODE_W-1:0]    report_key_a;
	logic [kmdr_pkg::CODE_W-1:0]    report_key_b;
	logic [kmdr_pkg::CODE_W-1:0]    report_key_c;
	logic [kmdr_pkg::CODE_W-1:0]    report_key_d;
	logic [kmdr_pkg::CODE_W-1:0]    report_key_e;
	logic [kmdr_pkg::CODE_W-1:0]    report_key_f;
	logic [kmdr_pkg::COUNT_W-1:0]   report_count;
	logic [kmdr_pkg::CODE_W-1:0]    meta_code;
	logic                           meta_stays;
	logic [kmdr_pkg::LEVEL_W-1:0]   backlight_level;
	logic [kmdr_pkg::CURS_W-1:0]    cursor_position;

	modport source (
		output valid, result_kind, report_key_a, report_key_b, report_key_c,
		       report_key_d, report_key_e, report_key_f, report_count, meta_code,
		       meta_stays, backlight_level, cursor_position,
		input  ready
	);
	modport sink (
		input  valid, result_kind, report_key_a, report_key_b, report_key_c,
		       report_key_d, report_key_e, report_key_f, report_count, meta_code,
		       meta_stays, backlight_level, cursor_position,
		output ready
	);
endinterface

/* rtl/key_matrix_debounce_report.sv */
`timescale 1ns / 1ps
`include "key_matrix_debounce_report_macros.svh"

// Debounced key matrix scanner with a six-key report and a meta menu.
// sample channel: one raw contact sample per item (row, column, contact,
//   scan_end, report_enable); the matrix is scanned one key per item.
// result channel: a report item on a scan_end item with report_enable set,
//   and a meta command item whenever a new key goes down in meta mode
//   (the meta item comes first when an item causes both).
// An accepted item is registered in stage 1; its results are pushed into
//   the result queue as it leaves stage 1, a second one behind the first.
// Throughput: one item per cycle unless the queue stalls stage 1. Key
//   histories sit in an 84-entry RAM read at accept and written as the
//   item leaves stage 1; a bypass spares a same-key follow-on item a bubble.
// Results go through a four-entry queue. The sample side is held off only
//   while that queue has fewer than two free places, so a stalled receiver
//   backs up into the sample channel after a couple of items.
// Reset: all keys released with zero history (per-key valid bits, no
//   clearing pass), meta mode off, cursor 0, backlight 8, report empty,
//   queue empty. The block takes items as soon as reset is released.
module key_matrix_debounce_report (
	input logic            clk,
	input logic            arst_n,
	kmdr_sample_if.sink    sample,
	kmdr_result_if.source  result
);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;
	localparam int ENTRY_W = kmdr_pkg::CODE_W + 1;

	// Input side
	logic                            acc;
	logic                            in_range_in;
	logic [kmdr_pkg::LOC_W-1:0]      loc_in;

	// Stage 1 registers
	logic                            v_s1;
	logic [kmdr_pkg::LOC_W-1:0]      loc_s1;
	logic                            in_range_s1;
	logic                            raw_s1;
	logic                            last_s1;
	logic                            ren_s1;
	logic [ENTRY_W-1:0]              mem_rd_s1;
	logic                            vld_rd_s1;
	logic                            fwd_s1;
	logic [ENTRY_W-1:0]              fwd_data_s1;

	// History RAM: {debounced, history}
	logic [ENTRY_W-1:0]              hist_mem [kmdr_pkg::NKEYS];
	logic [kmdr_pkg::NKEYS-1:0]      vld_q;

	// Block state
	logic                            meta_q;
	kmdr_pkg::key_code_t             held_q;
	logic [kmdr_pkg::CURS_W-1:0]     cursor_q;
	logic [kmdr_pkg::LEVEL_W-1:0]    bl_q;
	logic [kmdr_pkg::COUNT_W-1:0]    slots_q;
	kmdr_pkg::key_code_t             slot_q [kmdr_pkg::REPORT_SLOTS];
	logic                            any_q;

	// Stage 1 logic
	logic                            s1_fire;
	logic                            wr_en;
	logic [ENTRY_W-1:0]              entry_cur;
	logic [kmdr_pkg::CODE_W-1:0]     hist_new;
	logic                            down_new;
	logic [ENTRY_W-1:0]              entry_new;
	kmdr_pkg::key_code_t             key_code;
	logic                            key_dn;

	logic                            meta_nx;
	kmdr_pkg::key_code_t             held_nx;
	logic [kmdr_pkg::CURS_W-1:0]     cursor_nx;
	logic [kmdr_pkg::LEVEL_W-1:0]    bl_nx;
	logic [kmdr_pkg::COUNT_W-1:0]    slots_nx;
	kmdr_pkg::key_code_t             slot_nx [kmdr_pkg::REPORT_SLOTS];
	logic                            any_nx;
	logic                            meta_emit;
	logic                            rep_emit;
	logic                            stay;
	kmdr_pkg::key_code_t             resolved;
	logic [kmdr_pkg::LEVEL_W:0]      bl_sum;
	logic [kmdr_pkg::CURS_W:0]       cur_sum;

	kmdr_pkg::result_item_t          meta_res;
	kmdr_pkg::result_item_t          rep_res;
	kmdr_pkg::result_item_t          first_res;

	// Result queue
	kmdr_pkg::result_item_t          q_data [QDEPTH];
	logic [QPTR_W-1:0]               head_q;
	logic [QPTR_W-1:0]               tail_q;
	logic [QCNT_W-1:0]               cnt_q;
	logic                            push0;
	logic                            push1;
	logic                            pop;
	kmdr_pkg::result_item_t          head_res;

	assign acc = sample.valid && sample.ready;
	assign in_range_in = (sample.row_index < kmdr_pkg::ROW_W'(kmdr_pkg::ROWS))
		&& (sample.column_index < kmdr_pkg::COL_W'(kmdr_pkg::COLUMNS));
	assign loc_in = in_range_in
		? (kmdr_pkg::LOC_W'(sample.row_index) * kmdr_pkg::LOC_W'(kmdr_pkg::COLUMNS)
			+ kmdr_pkg::LOC_W'(sample.column_index))
		: '0;

	assign s1_fire = v_s1 && (cnt_q <= QCNT_W'(QDEPTH - 2));
	assign sample.ready = !v_s1 || s1_fire;
	assign wr_en = s1_fire && in_range_s1;

	// Debounce
	assign entry_cur = fwd_s1 ? fwd_data_s1 : (vld_rd_s1 ? mem_rd_s1 : '0);
	assign hist_new  = {entry_cur[kmdr_pkg::CODE_W-2:0], raw_s1};
	assign down_new  = (hist_new == 8'h00) ? 1'b0
		: (hist_new == 8'h01) ? 1'b1 : entry_cur[kmdr_pkg::CODE_W];
	assign entry_new = {down_new, hist_new};
	assign key_code  = kmdr_pkg::KEY_MAP[loc_s1];
	assign key_dn    = in_range_s1 && down_new;

	always_comb begin
		meta_nx   = meta_q;
		held_nx   = held_q;
		cursor_nx = cursor_q;
		bl_nx     = bl_q;
		slots_nx  = slots_q;
		slot_nx   = slot_q;
		any_nx    = any_q;
		meta_emit = 1'b0;
		stay      = 1'b0;
		resolved  = key_code;
		bl_sum    = {1'b0, bl_q} + {1'b0, kmdr_pkg::BACKLIGHT_STEP};
		cur_sum   = {1'b0, cursor_q} + 1'b1;
		if (key_dn) begin
			any_nx = 1'b1;
			if (key_code == kmdr_pkg::CODE_CIRCLE) begin
				if (!meta_q && held_q == '0) begin
					cursor_nx = '0;
					meta_nx   = 1'b1;
				end
			end else if (meta_q) begin
				if (held_q != key_code) begin
					meta_emit = 1'b1;
					held_nx   = key_code;
					if (key_code == kmdr_pkg::CODE_ENTER) begin
						resolved = (cursor_q < kmdr_pkg::CURS_W'(kmdr_pkg::MENU_DEPTH))
							? kmdr_pkg::MENU_MAP[cursor_q] : kmdr_pkg::CODE_ESC;
					end
					priority if (resolved == kmdr_pkg::CODE_F1) begin
						bl_nx = (bl_q < kmdr_pkg::BACKLIGHT_STEP) ? '0
							: bl_q - kmdr_pkg::BACKLIGHT_STEP;
						stay  = 1'b1;
					end else if (resolved == kmdr_pkg::CODE_F2) begin
						bl_nx = (bl_sum >= {1'b0, kmdr_pkg::BACKLIGHT_MAX})
							? kmdr_pkg::BACKLIGHT_MAX : bl_sum[kmdr_pkg::LEVEL_W-1:0];
						stay  = 1'b1;
					end else if (resolved == kmdr_pkg::CODE_UP) begin
						if (cursor_q != '0) begin
							cursor_nx = cursor_q - 1'b1;
						end
						stay = 1'b1;
					end else if (resolved == kmdr_pkg::CODE_DOWN) begin
						cursor_nx = (cur_sum >= (kmdr_pkg::CURS_W + 1)'(kmdr_pkg::MENU_DEPTH))
							? kmdr_pkg::CURS_W'(kmdr_pkg::MENU_DEPTH - 1)
							: cur_sum[kmdr_pkg::CURS_W-1:0];
						stay = 1'b1;
					end else begin
						stay = 1'b0;
					end
					if (!stay) begin
						meta_nx = 1'b0;
					end
				end
			end else if (held_q == '0 && ren_s1
					&& slots_q < kmdr_pkg::COUNT_W'(kmdr_pkg::REPORT_SLOTS)) begin
				for (int i = 0; i < kmdr_pkg::REPORT_SLOTS; i++) begin
					if (slots_q == kmdr_pkg::COUNT_W'(i)) begin
						slot_nx[i] = key_code;
					end
				end
				slots_nx = slots_q + 1'b1;
			end
		end
	end

	assign rep_emit = last_s1 && ren_s1;

	always_comb begin
		meta_res            = '0;
		meta_res.kind       = kmdr_pkg::KIND_META;
		meta_res.meta_code  = resolved;
		meta_res.meta_stays = stay;
		meta_res.backlight  = bl_nx;
		meta_res.cursor     = cursor_nx;

		rep_res             = '0;
		rep_res.kind        = kmdr_pkg::KIND_REPORT;
		for (int i = 0; i < kmdr_pkg::REPORT_SLOTS; i++) begin
			rep_res.keys[i] = slot_nx[i];
		end
		rep_res.count       = slots_nx;
		rep_res.backlight   = bl_nx;
		rep_res.cursor      = cursor_nx;
	end

	assign first_res = meta_emit ? meta_res : rep_res;
	assign push0 = s1_fire && (meta_emit || rep_emit);
	assign push1 = s1_fire && meta_emit && rep_emit;
	assign pop   = result.valid && result.ready;

	// Stage 1 control and the bypass for a same-key follow-on item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			vld_rd_s1 <= 1'b0;
			fwd_s1    <= 1'b0;
		end else begin
			if (acc) begin
				v_s1      <= 1'b1;
				vld_rd_s1 <= vld_q[loc_in];
				fwd_s1    <= wr_en && (loc_s1 == loc_in);
			end else if (s1_fire) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			loc_s1      <= loc_in;
			in_range_s1 <= in_range_in;
			raw_s1      <= sample.raw_pressed;
			last_s1     <= sample.scan_end;
			ren_s1      <= sample.report_enable;
			fwd_data_s1 <= entry_new;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mem_rd_s1 <= hist_mem[loc_in];
		end
		if (wr_en) begin
			hist_mem[loc_s1] <= entry_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			meta_q   <= 1'b0;
			held_q   <= '0;
			cursor_q <= '0;
			bl_q     <= kmdr_pkg::BACKLIGHT_RESET;
			slots_q  <= '0;
			any_q    <= 1'b0;
			for (int i = 0; i < kmdr_pkg::REPORT_SLOTS; i++) begin
				slot_q[i] <= '0;
			end
		end else if (s1_fire) begin
			if (in_range_s1) begin
				vld_q[loc_s1] <= 1'b1;
			end
			meta_q   <= meta_nx;
			cursor_q <= cursor_nx;
			bl_q     <= bl_nx;
			// end of scan: empty the report, drop the held key if nothing was down
			held_q   <= (last_s1 && !any_nx) ? '0 : held_nx;
			slots_q  <= last_s1 ? '0 : slots_nx;
			any_q    <= last_s1 ? 1'b0 : any_nx;
			for (int i = 0; i < kmdr_pkg::REPORT_SLOTS; i++) begin
				slot_q[i] <= last_s1 ? '0 : slot_nx[i];
			end
		end
	end

	// Result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + 1'b1;
			end
			tail_q <= tail_q + QPTR_W'(push0) + QPTR_W'(push1);
			cnt_q  <= cnt_q + QCNT_W'(push0) + QCNT_W'(push1) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push0) begin
			q_data[tail_q] <= first_res;
		end
		if (push1) begin
			q_data[tail_q + 1'b1] <= rep_res;
		end
	end

	assign head_res = q_data[head_q];

	assign result.valid           = (cnt_q != '0);
	assign result.result_kind     = head_res.kind;
	assign result.report_key_a    = head_res.keys[0];
	assign result.report_key_b    = head_res.keys[1];
	assign result.report_key_c    = head_res.keys[2];
	assign result.report_key_d    = head_res.keys[3];
	assign result.report_key_e    = head_res.keys[4];
	assign result.report_key_f    = head_res.keys[5];
	assign result.report_count    = head_res.count;
	assign result.meta_code       = head_res.meta_code;
	assign result.meta_stays      = head_res.meta_stays;
	assign result.backlight_level = head_res.backlight;
	assign result.cursor_position = head_res.cursor;

	`KMDR_ASSERT_ALWAYS(a_queue_bound, cnt_q <= QCNT_W'(QDEPTH), "result queue overflow")
	`KMDR_ASSERT_ALWAYS(a_level_bound, bl_q <= kmdr_pkg::BACKLIGHT_MAX, "backlight out of range")
	`KMDR_ASSERT_ALWAYS(a_cursor_bound,
		cursor_q < kmdr_pkg::CURS_W'(kmdr_pkg::MENU_DEPTH), "cursor out of range")
	`KMDR_ASSERT_ALWAYS(a_slot_bound,
		slots_q <= kmdr_pkg::COUNT_W'(kmdr_pkg::REPORT_SLOTS), "report slots overrun")
	`KMDR_ASSERT_NEXT(a_scan_clear, s1_fire && last_s1, slots_q == '0 && !any_q,
		"report not emptied at scan end")

endmodule

/* tb/key_matrix_debounce_report_test.sv */
`timescale 1ns / 1ps

module key_matrix_debounce_report_test;

	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;

	// own copy of the layout and the menu, so a wrong ROM in the RTL shows up
	localparam kmdr_pkg::key_code_t LAYOUT [kmdr_pkg::NKEYS] = '{
		8'h29,8'h3A,8'h3B,8'h3C,8'h3D,8'h3E,8'h3F,8'h40,8'h41,8'h42,8'h43,8'h44,8'h45,8'hA4,
		8'h35,8'h1E,8'h1F,8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'h27,8'h2D,8'h2E,8'h2A,
		8'h2B,8'h14,8'h1A,8'h08,8'h15,8'h17,8'h1C,8'h18,8'h0C,8'h12,8'h13,8'h2F,8'h30,8'h31,
		8'hE0,8'h65,8'h04,8'h16,8'h07,8'h09,8'h0A,8'h0B,8'h0D,8'h0E,8'h0F,8'h33,8'h34,8'h28,
		8'hE1,8'h4C,8'h1D,8'h1B,8'h06,8'h19,8'h05,8'h11,8'h10,8'h36,8'h37,8'h38,8'h52,8'hE5,
		8'hE7,8'hE3,8'hE4,8'h2C,8'hE2,8'hE6,8'h2C,8'h4B,8'h4E,8'h50,8'h51,8'h4F,8'h00,8'h00
	};
	localparam kmdr_pkg::key_code_t MENU_CODES [kmdr_pkg::MENU_DEPTH] = '{
		8'h29, 8'h1E, 8'h27, 8'h15, 8'h05, 8'h3A, 8'h3B, 8'h2C, 8'h16, 8'h13
	};

	// ESC, F1, F2, circle (twice, to enter meta mode more often), ENTER, UP, code 4F, zero codes
	localparam int HOT_ROW [10] = '{0, 0, 0, 0, 0, 3, 4, 5, 5, 5};
	localparam int HOT_COL [10] = '{0, 1, 2, 13, 13, 13, 12, 11, 12, 13};

	typedef struct packed {
		logic [kmdr_pkg::ROW_W-1:0] row;
		logic [kmdr_pkg::COL_W-1:0] col;
		logic                       raw;
		logic                       last;
		logic                       ren;
	} sample_item_t;

	typedef struct packed {
		kmdr_pkg::result_kind_t                                  kind;
		logic [kmdr_pkg::REPORT_SLOTS-1:0][kmdr_pkg::CODE_W-1:0] keys;
		logic [kmdr_pkg::COUNT_W-1:0]                            count;
		kmdr_pkg::key_code_t                                     code;
		logic                                                    stays;
		logic [kmdr_pkg::LEVEL_W-1:0]                            level;
		logic [kmdr_pkg::CURS_W-1:0]                             cursor;
	} key_result_t;

	logic clk = 1'b0;
	logic arst_n;

	kmdr_sample_if sample_bus();
	kmdr_result_if result_bus();

	key_matrix_debounce_report dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_bus),
		.result (result_bus)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	sample_item_t pending_samples [$];
	key_result_t  due_key_results [$];
	int           fail_count = 0;
	int           idle_cycles = 0;

	// matrix, meta and report state as the block should hold it
	logic [7:0]                                              key_history [kmdr_pkg::NKEYS];
	logic                                                    key_is_down [kmdr_pkg::NKEYS];
	logic                                                    in_meta;
	kmdr_pkg::key_code_t                                     held_code;
	logic [kmdr_pkg::CURS_W-1:0]                             menu_row;
	logic [kmdr_pkg::LEVEL_W-1:0]                            backlight;
	int unsigned                                             slots_used;
	logic [kmdr_pkg::REPORT_SLOTS-1:0][kmdr_pkg::CODE_W-1:0] gathered;
	logic                                                    scan_saw_key;

	task automatic debounce_and_report(input logic [kmdr_pkg::ROW_W-1:0] row,
			input logic [kmdr_pkg::COL_W-1:0] col, input logic raw, input logic last,
			input logic ren);
		int unsigned         loc;
		kmdr_pkg::key_code_t code;
		kmdr_pkg::key_code_t run_code;
		logic                stay;
		key_result_t         res;
		if (row < kmdr_pkg::ROWS && col < kmdr_pkg::COLUMNS) begin
			loc = row * kmdr_pkg::COLUMNS + col;
			key_history[loc] = {key_history[loc][6:0], raw};
			if (key_history[loc] == 8'h00) key_is_down[loc] = 1'b0;
			else if (key_history[loc] == 8'h01) key_is_down[loc] = 1'b1;
			if (key_is_down[loc]) begin
				code = LAYOUT[loc];
				scan_saw_key = 1'b1;
				if (code == kmdr_pkg::CODE_CIRCLE) begin
					if (!in_meta && held_code == 8'h00) begin
						menu_row = '0;
						in_meta = 1'b1;
					end
				end else if (in_meta) begin
					if (held_code != code) begin
						run_code = code;
						if (run_code == kmdr_pkg::CODE_ENTER)
							run_code = (int'(menu_row) < kmdr_pkg::MENU_DEPTH)
								? MENU_CODES[menu_row] : kmdr_pkg::CODE_ESC;
						stay = 1'b1;
						case (run_code)
							kmdr_pkg::CODE_F1: begin
								backlight = (int'(backlight) < int'(kmdr_pkg::BACKLIGHT_STEP))
									? '0 : backlight - kmdr_pkg::BACKLIGHT_STEP;
							end
							kmdr_pkg::CODE_F2: begin
								backlight = (int'(backlight) + int'(kmdr_pkg::BACKLIGHT_STEP)
									>= int'(kmdr_pkg::BACKLIGHT_MAX)) ? kmdr_pkg::BACKLIGHT_MAX
									: backlight + kmdr_pkg::BACKLIGHT_STEP;
							end
							kmdr_pkg::CODE_UP: begin
								if (menu_row != '0) menu_row = menu_row - 1'b1;
							end
							kmdr_pkg::CODE_DOWN: begin
								if (int'(menu_row) < kmdr_pkg::MENU_DEPTH - 1)
									menu_row = menu_row + 1'b1;
							end
							default: stay = 1'b0;
						endcase
						held_code = code;
						if (!stay) in_meta = 1'b0;
						res = '0;
						res.kind = kmdr_pkg::KIND_META;
						res.code = run_code;
						res.stays = stay;
						res.level = backlight;
						res.cursor = menu_row;
						due_key_results.push_back(res);
					end
				end else if (held_code == 8'h00) begin
					if (ren && slots_used < kmdr_pkg::REPORT_SLOTS) begin
						gathered[slots_used] = code;
						slots_used++;
					end
				end
			end
		end
		if (last) begin
			if (ren) begin
				res = '0;
				res.kind = kmdr_pkg::KIND_REPORT;
				res.keys = gathered;
				res.count = kmdr_pkg::COUNT_W'(slots_used);
				res.level = backlight;
				res.cursor = menu_row;
				due_key_results.push_back(res);
			end
			// a scan with nothing held lets a meta key fire again
			if (!scan_saw_key) held_code = 8'h00;
			scan_saw_key = 1'b0;
			slots_used = 0;
			gathered = '0;
		end
	endtask

	// sender: bursts of items with random gaps
	sample_item_t next_item;
	int           burst_left;
	int           gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_bus.valid <= 1'b0;
			sample_bus.row_index <= '0;
			sample_bus.column_index <= '0;
			sample_bus.raw_pressed <= 1'b0;
			sample_bus.scan_end <= 1'b0;
			sample_bus.report_enable <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (sample_bus.valid && sample_bus.ready)
				debounce_and_report(sample_bus.row_index, sample_bus.column_index,
					sample_bus.raw_pressed, sample_bus.scan_end, sample_bus.report_enable);
			if (!sample_bus.valid || sample_bus.ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					sample_bus.valid <= 1'b0;
				end else if (pending_samples.size() != 0) begin
					next_item = pending_samples.pop_front();
					sample_bus.row_index <= next_item.row;
					sample_bus.column_index <= next_item.col;
					sample_bus.raw_pressed <= next_item.raw;
					sample_bus.scan_end <= next_item.last;
					sample_bus.report_enable <= next_item.ren;
					sample_bus.valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					sample_bus.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	// receiver: stall pattern switches between always ready, a fixed duty,
	// coin flips and long stalls
	key_result_t got_result;
	key_result_t want_result;
	int          stall_mode;
	int          mode_left;
	int          stall_left;
	logic [1:0]  ready_phase;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			stall_mode <= 0;
			mode_left <= 0;
			stall_left <= 0;
			ready_phase <= '0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				got_result.kind = kmdr_pkg::result_kind_t'(result_bus.result_kind);
				got_result.keys[0] = result_bus.report_key_a;
				got_result.keys[1] = result_bus.report_key_b;
				got_result.keys[2] = result_bus.report_key_c;
				got_result.keys[3] = result_bus.report_key_d;
				got_result.keys[4] = result_bus.report_key_e;
				got_result.keys[5] = result_bus.report_key_f;
				got_result.count = result_bus.report_count;
				got_result.code = result_bus.meta_code;
				got_result.stays = result_bus.meta_stays;
				got_result.level = result_bus.backlight_level;
				got_result.cursor = result_bus.cursor_position;
				if (due_key_results.size() == 0) begin
					fail_count++;
					$display("%0t: result item with none expected, kind %0d code %0h count %0d",
						$time, got_result.kind, got_result.code, got_result.count);
				end else begin
					want_result = due_key_results.pop_front();
					check_field("result_kind", 8'(want_result.kind), 8'(got_result.kind));
					for (int i = 0; i < kmdr_pkg::REPORT_SLOTS; i++)
						check_field($sformatf("report_key slot %0d", i),
							want_result.keys[i], got_result.keys[i]);
					check_field("report_count", 8'(want_result.count), 8'(got_result.count));
					check_field("meta_code", want_result.code, got_result.code);
					check_field("meta_stays", 8'(want_result.stays), 8'(got_result.stays));
					check_field("backlight_level", 8'(want_result.level),
						8'(got_result.level));
					check_field("cursor_position", 8'(want_result.cursor),
						8'(got_result.cursor));
				end
			end
			ready_phase <= ready_phase + 1'b1;
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(20, 80);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: result_bus.ready <= 1'b1;
				1: result_bus.ready <= (ready_phase != 2'd3);
				2: result_bus.ready <= 1'($urandom_range(0, 1));
				default: begin
					if (stall_left != 0) begin
						stall_left <= stall_left - 1;
						result_bus.ready <= 1'b0;
					end else begin
						result_bus.ready <= 1'b1;
						if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(3, 12);
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("key_matrix_debounce_report_test NOT OK");
		$finish;
	end

	task automatic queue_sample(input int row, input int col, input int raw,
			input int last, input int ren);
		sample_item_t item;
		item.row = kmdr_pkg::ROW_W'(row);
		item.col = kmdr_pkg::COL_W'(col);
		item.raw = 1'(raw);
		item.last = 1'(last);
		item.ren = 1'(ren);
		pending_samples.push_back(item);
	endtask

	// sample outside the matrix: ignored apart from its scan_end
	task automatic queue_stray(input int last, input int ren);
		int row;
		int col;
		row = $urandom_range(0, 7);
		col = $urandom_range(0, 15);
		if (row < kmdr_pkg::ROWS && col < kmdr_pkg::COLUMNS)
			row = $urandom_range(kmdr_pkg::ROWS, 7);
		queue_sample(row, col, $urandom_range(0, 1), last, ren);
	endtask

	task automatic wait_until_drained();
		do @(negedge clk);
		while (pending_samples.size() != 0 || sample_bus.valid || due_key_results.size() != 0);
	endtask

	// scans over a small set of keys held for a while; each key follows a
	// pressed/released target with the odd bounce, plus stray samples
	task automatic queue_random_scans(input int count);
		int hot_r [6];
		int hot_c [6];
		bit hot_on [6];
		int nhot;
		int scans_left;
		int added;
		int first;
		int i;
		int ren_scan;
		int pick;
		scans_left = 0;
		added = 0;
		nhot = 1;
		while (added < count) begin
			if (scans_left == 0) begin
				nhot = $urandom_range(1, 6);
				for (int k = 0; k < nhot; k++) begin
					if ($urandom_range(0, 1) == 0) begin
						pick = $urandom_range(0, 9);
						hot_r[k] = HOT_ROW[pick];
						hot_c[k] = HOT_COL[pick];
					end else begin
						hot_r[k] = $urandom_range(0, kmdr_pkg::ROWS - 1);
						hot_c[k] = $urandom_range(0, kmdr_pkg::COLUMNS - 1);
					end
					hot_on[k] = 1'($urandom_range(0, 1));
				end
				scans_left = $urandom_range(8, 30);
			end
			scans_left--;
			ren_scan = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 14) == 0) begin
				// empty scan: nothing held, so held meta keys clear
				queue_stray(1, ren_scan);
				added++;
			end else begin
				first = $urandom_range(0, nhot - 1);
				for (int k = 0; k < nhot; k++) begin
					i = (first + k) % nhot;
					if ($urandom_range(0, 5) == 0) hot_on[i] = !hot_on[i];
					queue_sample(hot_r[i], hot_c[i], hot_on[i] ^ ($urandom_range(0, 9) == 0), 0,
						($urandom_range(0, 9) == 0) ? !ren_scan : ren_scan);
					added++;
					if ($urandom_range(0, 11) == 0) begin
						if ($urandom_range(0, 1) == 0)
							queue_stray(0, $urandom_range(0, 1));
						else
							queue_sample($urandom_range(0, kmdr_pkg::ROWS - 1),
								$urandom_range(0, kmdr_pkg::COLUMNS - 1),
								$urandom_range(0, 1), 0, $urandom_range(0, 1));
						added++;
					end
				end
				if ($urandom_range(0, 3) == 0) begin
					queue_stray(1, ren_scan);
					added++;
				end else begin
					pending_samples[$].last = 1'b1;
					pending_samples[$].ren = 1'(ren_scan);
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		sample_bus.valid = 1'b0;
		sample_bus.row_index = '0;
		sample_bus.column_index = '0;
		sample_bus.raw_pressed = 1'b0;
		sample_bus.scan_end = 1'b0;
		sample_bus.report_enable = 1'b0;
		result_bus.ready = 1'b0;
		for (int k = 0; k < kmdr_pkg::NKEYS; k++) begin
			key_history[k] = 8'h00;
			key_is_down[k] = 1'b0;
		end
		in_meta = 1'b0;
		held_code = 8'h00;
		menu_row = '0;
		backlight = kmdr_pkg::BACKLIGHT_RESET;
		slots_used = 0;
		gathered = '0;
		scan_saw_key = 1'b0;

		// single key pressed and reported in the same item
		queue_sample(0, 0, 1, 1, 1);
		// out of range rows and columns; scan end still reports
		queue_sample(6, 3, 1, 0, 1);
		queue_sample(7, 15, 1, 1, 1);
		// seven keys in one scan: the seventh is dropped
		for (int c = 1; c <= 7; c++)
			queue_sample(1, c, 1, (c == 7), 1);
		// circle into meta mode, F2 to the top, held F2 does not repeat
		queue_sample(0, 13, 1, 0, 0);
		queue_sample(0, 2, 1, 0, 1);
		queue_sample(0, 2, 1, 1, 1);
		// key 4F is no menu key and ends meta mode; then UP and ENTER are not gathered
		queue_sample(5, 11, 1, 0, 1);
		queue_sample(4, 12, 1, 0, 1);
		queue_sample(5, 11, 0, 0, 1);
		queue_sample(3, 13, 1, 1, 1);
		// empty scan without report clears the held key
		queue_sample(6, 0, 0, 1, 0);
		// back into meta, F1 down, then a zero-code key exits
		queue_sample(0, 13, 1, 0, 1);
		queue_sample(0, 1, 1, 0, 1);
		queue_sample(5, 12, 1, 0, 1);
		// zero code is reported like any other key
		queue_sample(5, 13, 1, 1, 1);
		queue_sample(7, 14, 0, 1, 1);
		// key seen with reporting off is not gathered
		queue_sample(1, 8, 1, 0, 0);
		queue_sample(1, 9, 1, 1, 1);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait_until_drained();
		// sender holds off until every result is in, between chunks
		for (int chunk = 0; chunk < 4; chunk++) begin
			queue_random_scans(175);
			wait_until_drained();
		end
		repeat (TAIL_CYCLES) @(negedge clk);

		if (due_key_results.size() != 0) begin
			fail_count++;
			$display("%0t: %0d result items still expected", $time, due_key_results.size());
		end
		if (fail_count == 0)
			$display("key_matrix_debounce_report_test OK");
		else
			$display("key_matrix_debounce_report_test NOT OK");
		$finish;
	end

endmodule

/* key_matrix_debounce_report.f */
+incdir+rtl
rtl/kmdr_pkg.sv
rtl/kmdr_sample_if.sv
rtl/kmdr_result_if.sv
rtl/key_matrix_debounce_report.sv
tb/key_matrix_debounce_report_test.sv
